### hdl/dgsa_pkg.sv
// package for the distance gated scan averager
// field widths, register indexes, reset values and shared structs
// no dependencies
package dgsa_pkg;

    // fixed field widths
    localparam int OP_W       = 1;
    localparam int SPEED_W    = 16;
    localparam int MS_W       = 16;
    localparam int RANGE_W    = 16;
    localparam int IDX_W      = 7;
    localparam int AVG_W      = 16;
    localparam int DIST_W     = 32;
    localparam int SUM_W      = 19;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_SPEED  = 1'b0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT_UM   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELAPSED_MS = 1'b1;

    // reset values
    localparam logic [DIST_W-1:0] RST_SNAPSHOT_UM    = 32'd300000;
    localparam logic [MS_W-1:0]   RST_MAX_ELAPSED_MS = 16'd300;

    // default geometry
    localparam int DEF_SCAN_LENGTH    = 80;
    localparam int DEF_SCANS_AVERAGED = 3;

    // output queue
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_PTR_W = 3;
    localparam int OFIFO_CNT_W = 4;

    // one captured sample heading for the sum store
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               emit;
        logic               last;
        logic [IDX_W-1:0]   idx;
        logic [RANGE_W-1:0] range_mm;
    } t_acc;

    // one result beat
    typedef struct packed {
        logic [AVG_W-1:0] average_mm;
        logic [IDX_W-1:0] out_index;
        logic             last;
    } t_res;

endpackage

### hdl/distance_gated_scan_averager.sv
// Distance gated scan averager.
// Input channel (i_in_valid / o_in_stall) carries speed commands and laser
// range samples; one beat may be accepted every clock cycle while o_in_stall
// is low. Speed commands update the travelled distance and never produce a
// result. A sample whose scan is captured does one read-modify-write of its
// element's sum in the sum store; samples of the final scan of a set produce
// one result beat. Output channel (o_out_valid / i_out_stall): a result
// passes the capture decision register, the sum store read and add stage and
// the divide stage, then waits in an 8-entry queue. The input stalls when
// queue plus in-flight items could overrun the queue, so a stalled receiver
// holds the input off and nothing is lost. Sustained rate is 1 item per
// cycle while the output is not stalled, set by the single read and single
// write port of the sum store with write forwarding.
// Config port (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
// capture threshold in um, index 1 the elapsed-time clamp in ms; write
// only while idle.
// Reset (synchronous, i_rst_n low) restores the register defaults, sets the
// distance to the threshold and clears the scan count; the sum store is not
// cleared and needs no sweep.
// uses dgsa_pkg, dgsa_ctrl, dgsa_accum, dgsa_ofifo (dgsa_ram through dgsa_accum)
module distance_gated_scan_averager #(
    parameter int SCAN_LENGTH    = dgsa_pkg::DEF_SCAN_LENGTH,
    parameter int SCANS_AVERAGED = dgsa_pkg::DEF_SCANS_AVERAGED
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dgsa_pkg::OP_W-1:0]           i_operation,
    input  logic signed [dgsa_pkg::SPEED_W-1:0] i_new_speed_mm_s,
    input  logic [dgsa_pkg::MS_W-1:0]           i_elapsed_ms,
    input  logic [dgsa_pkg::RANGE_W-1:0]        i_range_mm,
    input  logic [dgsa_pkg::IDX_W-1:0]          i_element_index,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dgsa_pkg::AVG_W-1:0]          o_average_mm,
    output logic [dgsa_pkg::IDX_W-1:0]          o_out_index,
    output logic                                o_last,
    // configuration port
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dgsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dgsa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                               in_accept;
    logic                               cfg_we;
    dgsa_pkg::t_acc                     acc;
    logic [1:0]                         inflight;
    logic                               push;
    dgsa_pkg::t_res                     push_res;
    dgsa_pkg::t_res                     out_res;
    logic [dgsa_pkg::OFIFO_CNT_W-1:0]   fifo_count;

    // handshakes; in-flight covers the decision register and both store stages
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = ((4'(fifo_count) + 4'(inflight) + 4'(acc.valid))
                          >= 4'(dgsa_pkg::OFIFO_DEPTH));
    assign in_accept   = i_in_valid && !o_in_stall;

    dgsa_ctrl #(
        .SCAN_LENGTH    (SCAN_LENGTH),
        .SCANS_AVERAGED (SCANS_AVERAGED)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_operation      (i_operation),
        .i_new_speed_mm_s (i_new_speed_mm_s),
        .i_elapsed_ms     (i_elapsed_ms),
        .i_range_mm       (i_range_mm),
        .i_element_index  (i_element_index),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_acc            (acc)
    );

    dgsa_accum #(
        .SCAN_LENGTH    (SCAN_LENGTH),
        .SCANS_AVERAGED (SCANS_AVERAGED)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .o_inflight (inflight),
        .o_push     (push),
        .o_push_res (push_res)
    );

    dgsa_ofifo u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_res  (push_res),
        .o_count     (fifo_count),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (out_res)
    );

    // result fields
    assign o_average_mm = out_res.average_mm;
    assign o_out_index  = out_res.out_index;
    assign o_last       = out_res.last;

endmodule

### hdl/dgsa_ram.sv
// generic simple dual port ram with registered read
// read during write to the same address returns the old data
// no dependencies
module dgsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/dgsa_ctrl.sv
// control front end: config registers, travelled distance, capture decision
// turns accepted input beats into sum store requests; uses dgsa_pkg
module dgsa_ctrl #(
    parameter int SCAN_LENGTH    = dgsa_pkg::DEF_SCAN_LENGTH,
    parameter int SCANS_AVERAGED = dgsa_pkg::DEF_SCANS_AVERAGED
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [dgsa_pkg::OP_W-1:0]        i_operation,
    input  logic signed [dgsa_pkg::SPEED_W-1:0] i_new_speed_mm_s,
    input  logic [dgsa_pkg::MS_W-1:0]        i_elapsed_ms,
    input  logic [dgsa_pkg::RANGE_W-1:0]     i_range_mm,
    input  logic [dgsa_pkg::IDX_W-1:0]       i_element_index,
    input  logic                             i_cfg_we,
    input  logic [dgsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dgsa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dgsa_pkg::t_acc                   o_acc
);

    localparam int CNT_W = (SCANS_AVERAGED > 1) ? $clog2(SCANS_AVERAGED) : 1;

    logic [dgsa_pkg::DIST_W-1:0]         r_snapshot_um;
    logic [dgsa_pkg::MS_W-1:0]           r_max_elapsed_ms;
    logic [dgsa_pkg::DIST_W-1:0]         r_distance_um;
    logic signed [dgsa_pkg::SPEED_W-1:0] r_prev_speed;
    logic [CNT_W-1:0]                    r_scans_taken;
    logic                                r_capturing;
    dgsa_pkg::t_acc                      r_acc;
    dgsa_pkg::t_acc                      n_acc;

    logic [dgsa_pkg::SPEED_W-1:0]  speed_mag;
    logic [dgsa_pkg::MS_W-1:0]     elapsed_clamped;
    logic [dgsa_pkg::DIST_W-1:0]   add_um;
    logic [dgsa_pkg::DIST_W:0]     dist_sum;
    logic [dgsa_pkg::DIST_W-1:0]   dist_next;
    logic                          is_sample;
    logic                          cap_now;
    logic                          idx_ok;
    logic                          idx_last;
    logic [CNT_W:0]                cnt_inc;
    logic                          set_done;

    // distance increment: |previous speed| times clamped elapsed time
    always_comb begin
        speed_mag = r_prev_speed[dgsa_pkg::SPEED_W-1]
                  ? dgsa_pkg::SPEED_W'(~r_prev_speed + 1'b1)
                  : dgsa_pkg::SPEED_W'(r_prev_speed);
        elapsed_clamped = (i_elapsed_ms > r_max_elapsed_ms) ? r_max_elapsed_ms
                                                            : i_elapsed_ms;
        add_um   = 32'(speed_mag) * 32'(elapsed_clamped);
        dist_sum = 33'(r_distance_um) + 33'(add_um);
        dist_next = dist_sum[dgsa_pkg::DIST_W] ? '1 : dist_sum[dgsa_pkg::DIST_W-1:0];
    end

    // capture decision and set bookkeeping for a sample
    always_comb begin
        is_sample = (i_operation == dgsa_pkg::OP_SAMPLE);
        cap_now   = (i_element_index == '0) ? (r_distance_um >= r_snapshot_um)
                                            : r_capturing;
        idx_ok    = (32'(i_element_index) < 32'(SCAN_LENGTH));
        idx_last  = (32'(i_element_index) == 32'(SCAN_LENGTH - 1));
        cnt_inc   = (CNT_W + 1)'(r_scans_taken) + 1'b1;
        set_done  = (cnt_inc >= (CNT_W + 1)'(SCANS_AVERAGED));

        n_acc.valid    = i_accept && is_sample && cap_now && idx_ok;
        n_acc.first    = (r_scans_taken == '0);
        n_acc.emit     = set_done;
        n_acc.last     = idx_last;
        n_acc.idx      = i_element_index;
        n_acc.range_mm = i_range_mm;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snapshot_um    <= dgsa_pkg::RST_SNAPSHOT_UM;
            r_max_elapsed_ms <= dgsa_pkg::RST_MAX_ELAPSED_MS;
            r_distance_um    <= dgsa_pkg::RST_SNAPSHOT_UM;
            r_prev_speed     <= '0;
            r_scans_taken    <= '0;
            r_capturing      <= 1'b0;
            r_acc.valid      <= 1'b0;
        end else begin
            r_acc <= n_acc;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dgsa_pkg::CFG_SNAPSHOT_UM: begin
                        r_snapshot_um <= i_cfg_data;
                    end
                    dgsa_pkg::CFG_MAX_ELAPSED_MS: begin
                        r_max_elapsed_ms <= i_cfg_data[dgsa_pkg::MS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (i_accept && !is_sample) begin
                // speed command
                r_distance_um <= dist_next;
                r_prev_speed  <= i_new_speed_mm_s;
            end else if (i_accept) begin
                // laser sample
                if (cap_now && idx_ok && idx_last) begin
                    r_capturing <= 1'b0;
                    if (set_done) begin
                        r_scans_taken <= '0;
                        r_distance_um <= '0;
                    end else begin
                        r_scans_taken <= cnt_inc[CNT_W-1:0];
                    end
                end else begin
                    r_capturing <= cap_now;
                end
            end
        end
    end

    assign o_acc = r_acc;

endmodule

### hdl/dgsa_accum.sv
// sum store read-modify-write pipeline and averaging divider
// uses dgsa_pkg and dgsa_ram
module dgsa_accum #(
    parameter int SCAN_LENGTH    = dgsa_pkg::DEF_SCAN_LENGTH,
    parameter int SCANS_AVERAGED = dgsa_pkg::DEF_SCANS_AVERAGED
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dgsa_pkg::t_acc i_acc,
    output logic [1:0]     o_inflight,
    output logic           o_push,
    output dgsa_pkg::t_res o_push_res
);

    localparam int AW = (SCAN_LENGTH > 1) ? $clog2(SCAN_LENGTH) : 1;
    localparam int XW = (AW > dgsa_pkg::IDX_W) ? AW : dgsa_pkg::IDX_W;
    localparam int SHIFT_L = (SCANS_AVERAGED > 1) ? $clog2(SCANS_AVERAGED) : 0;
    localparam int DIV_SHIFT = dgsa_pkg::SUM_W + SHIFT_L;
    localparam int MULT_W = dgsa_pkg::SUM_W + 1;
    localparam int PROD_W = dgsa_pkg::SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + 64'(SCANS_AVERAGED) - 64'd1) / 64'(SCANS_AVERAGED));

    dgsa_pkg::t_acc               r_s1;
    logic                         r_wr_v;
    logic [AW-1:0]                r_wr_addr;
    logic [dgsa_pkg::SUM_W-1:0]   r_wr_data;
    logic                         r_s2_v;
    logic [dgsa_pkg::SUM_W-1:0]   r_s2_sum;
    logic [dgsa_pkg::IDX_W-1:0]   r_s2_idx;
    logic                         r_s2_last;

    logic [XW-1:0]                in_idx_x;
    logic [XW-1:0]                s1_idx_x;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                s1_addr;
    logic [dgsa_pkg::SUM_W-1:0]   ram_rdata;
    logic [dgsa_pkg::SUM_W-1:0]   old_sum;
    logic [dgsa_pkg::SUM_W-1:0]   new_sum;
    logic [PROD_W-1:0]            prod;
    logic [PROD_W-1:0]            quot;

    // element addresses
    always_comb begin
        in_idx_x = XW'(i_acc.idx);
        s1_idx_x = XW'(r_s1.idx);
        rd_addr  = in_idx_x[AW-1:0];
        s1_addr  = s1_idx_x[AW-1:0];
    end

    dgsa_ram #(
        .WIDTH (dgsa_pkg::SUM_W),
        .DEPTH (SCAN_LENGTH),
        .AW    (AW)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1.valid),
        .i_waddr (s1_addr),
        .i_wdata (new_sum),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // modify: forward the last write when it hit the same element
    always_comb begin
        old_sum = (r_wr_v && (r_wr_addr == s1_addr)) ? r_wr_data : ram_rdata;
        new_sum = r_s1.first ? dgsa_pkg::SUM_W'(r_s1.range_mm)
                             : dgsa_pkg::SUM_W'(old_sum + dgsa_pkg::SUM_W'(r_s1.range_mm));
    end

    // divide by the scan count through a reciprocal multiply
    always_comb begin
        prod = PROD_W'(r_s2_sum) * PROD_W'(DIV_MULT);
        quot = prod >> DIV_SHIFT;
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_wr_v     <= 1'b0;
            r_s2_v     <= 1'b0;
        end else begin
            r_s1      <= i_acc;
            r_s2_v    <= r_s1.valid && r_s1.emit;
            if (r_s1.valid) begin
                r_wr_v    <= 1'b1;
                r_wr_addr <= s1_addr;
                r_wr_data <= new_sum;
            end
        end
        r_s2_sum  <= new_sum;
        r_s2_idx  <= r_s1.idx;
        r_s2_last <= r_s1.last;
    end

    assign o_inflight            = 2'(r_s1.valid) + 2'(r_s2_v);
    assign o_push                = r_s2_v;
    assign o_push_res.average_mm = quot[dgsa_pkg::AVG_W-1:0];
    assign o_push_res.out_index  = r_s2_idx;
    assign o_push_res.last       = r_s2_last;

endmodule

### hdl/dgsa_ofifo.sv
// small result queue in front of the output channel
// uses dgsa_pkg
module dgsa_ofifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  dgsa_pkg::t_res                     i_push_res,
    output logic [dgsa_pkg::OFIFO_CNT_W-1:0]   o_count,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output dgsa_pkg::t_res                     o_out_res
);

    dgsa_pkg::t_res                       r_mem [dgsa_pkg::OFIFO_DEPTH];
    logic [dgsa_pkg::OFIFO_PTR_W-1:0]     r_wr_ptr;
    logic [dgsa_pkg::OFIFO_PTR_W-1:0]     r_rd_ptr;
    logic [dgsa_pkg::OFIFO_CNT_W-1:0]     r_count;
    logic                                 pop;

    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && !i_out_stall;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_res;
        end
    end

    assign o_count   = r_count;
    assign o_out_res = r_mem[r_rd_ptr];

endmodule
